// File: rtl/core/wmds_pkg.sv
// Package for the window minimum-distance scan scorer.
// Register indexes, reset values, widths, config struct and helpers; no dependencies.
package wmds_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 15;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned RAD_W   = 4;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned SCORE_W = 30;
  localparam int unsigned PROD_W  = SUM_W + COEF_W;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned IDX_W   = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_UNKNOWN   = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_COEF      = 2'd3
  } reg_idx_t;

  localparam logic [VAL_W-1:0]  THRESHOLD_RST = 16'd32768;
  localparam logic [VAL_W-1:0]  UNKNOWN_RST   = 16'd0;
  localparam logic [RAD_W-1:0]  RADIUS_RST    = 4'd1;
  localparam logic [COEF_W-1:0] COEF_RST      = 24'd65536;

  typedef struct packed {
    logic [VAL_W-1:0]  threshold;
    logic [VAL_W-1:0]  unknown;
    logic [RAD_W-1:0]  radius;
    logic [COEF_W-1:0] coef;
    logic              restart;
    logic [RAD_W-1:0]  restart_radius;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] pmin;
    logic [SUM_W-1:0]  sum;
    logic              last;
  } point_res_t;

  // 2(k+1)^2 for an effective radius k
  function automatic logic [DIST_W-1:0] init_min(input logic [RAD_W-1:0] k);
    logic [DIST_W-1:0] k1;
    logic [DIST_W-1:0] sq;
    k1 = DIST_W'(k) + DIST_W'(1);
    sq = k1 * k1;
    return {sq[DIST_W-2:0], 1'b0};
  endfunction

endpackage

// File: rtl/core/wmds_cfg.sv
// Configuration registers of the scan scorer.
// Depends on wmds_pkg.
module wmds_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wmds_pkg::IDX_W-1:0]  cfg_index,
  input  logic [wmds_pkg::CFG_W-1:0]  cfg_data,
  output wmds_pkg::cfg_t              cfg
);

  logic [wmds_pkg::VAL_W-1:0]  threshold_r;
  logic [wmds_pkg::VAL_W-1:0]  unknown_r;
  logic [wmds_pkg::RAD_W-1:0]  radius_r;
  logic [wmds_pkg::COEF_W-1:0] coef_r;
  wmds_pkg::reg_idx_t          idx;

  assign idx = wmds_pkg::reg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= wmds_pkg::THRESHOLD_RST;
      unknown_r   <= wmds_pkg::UNKNOWN_RST;
      radius_r    <= wmds_pkg::RADIUS_RST;
      coef_r      <= wmds_pkg::COEF_RST;
    end else if (cfg_we) begin
      unique case (idx)
        wmds_pkg::REG_THRESHOLD: threshold_r <= cfg_data[wmds_pkg::VAL_W-1:0];
        wmds_pkg::REG_UNKNOWN:   unknown_r   <= cfg_data[wmds_pkg::VAL_W-1:0];
        wmds_pkg::REG_RADIUS:    radius_r    <= cfg_data[wmds_pkg::RAD_W-1:0];
        wmds_pkg::REG_COEF:      coef_r      <= cfg_data[wmds_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.threshold      = threshold_r;
    cfg.unknown        = unknown_r;
    cfg.radius         = radius_r;
    cfg.coef           = coef_r;
    cfg.restart        = cfg_we && (idx == wmds_pkg::REG_RADIUS);
    cfg.restart_radius = cfg_data[wmds_pkg::RAD_W-1:0];
  end

endmodule

// File: rtl/core/wmds_track.sv
// Window walk, running minimum and saturating distance sum, with result register.
// Depends on wmds_pkg.
module wmds_track #(
  parameter int unsigned MAX_RADIUS = wmds_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        cell_valid,
  input  logic [wmds_pkg::VAL_W-1:0]  hit,
  input  logic [wmds_pkg::VAL_W-1:0]  missed,
  input  logic                        last_scan,
  input  wmds_pkg::cfg_t              cfg,
  output wmds_pkg::point_res_t        res
);

  localparam int unsigned OFS_W = $clog2(2 * MAX_RADIUS + 1);

  logic [OFS_W-1:0]             col_r, col_nxt;
  logic [OFS_W-1:0]             row_r, row_nxt;
  logic [wmds_pkg::DIST_W-1:0]  min_r, min_nxt;
  logic [wmds_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  wmds_pkg::point_res_t         res_r, res_nxt;

  logic [wmds_pkg::RAD_W-1:0]   k, k_new;
  logic [OFS_W-1:0]             k_o, span;
  logic [wmds_pkg::DIST_W-1:0]  cell_dist, min_upd;
  logic [wmds_pkg::SUM_W:0]     sum_full;
  logic [wmds_pkg::SUM_W-1:0]   sum_sat;
  logic                         usable, row_end, point_end;

  function automatic logic [wmds_pkg::RAD_W-1:0] clamp(input logic [wmds_pkg::RAD_W-1:0] r);
    if (32'(r) > 32'(MAX_RADIUS)) return wmds_pkg::RAD_W'(MAX_RADIUS);
    else return r;
  endfunction

  function automatic logic [wmds_pkg::DIST_W-1:0] sq_ofs(input logic [OFS_W-1:0] pos,
                                                          input logic [OFS_W-1:0] kk);
    logic [OFS_W-1:0]   d;
    logic [2*OFS_W-1:0] p;
    d = (pos >= kk) ? pos - kk : kk - pos;
    p = (2*OFS_W)'(d) * (2*OFS_W)'(d);
    return wmds_pkg::DIST_W'(p);
  endfunction

  always_comb begin
    k         = clamp(cfg.radius);
    k_new     = clamp(cfg.restart_radius);
    k_o       = OFS_W'(k);
    span      = OFS_W'({1'b0, k, 1'b0});
    usable    = (hit != cfg.unknown) && (missed != cfg.unknown) &&
                (hit >= cfg.threshold) && (missed <= cfg.threshold);
    cell_dist = sq_ofs(col_r, k_o) + sq_ofs(row_r, k_o);
    min_upd   = (usable && (cell_dist < min_r)) ? cell_dist : min_r;
    row_end   = col_r >= span;
    point_end = row_end && (row_r >= span);
    sum_full  = {1'b0, sum_r} + (wmds_pkg::SUM_W+1)'(min_upd);
    sum_sat   = sum_full[wmds_pkg::SUM_W] ? wmds_pkg::SUM_MAX : sum_full[wmds_pkg::SUM_W-1:0];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    min_nxt = min_r;
    sum_nxt = sum_r;
    res_nxt = res_r;
    if (adv) begin
      res_nxt.valid = 1'b0;
    end
    if (cfg.restart) begin
      col_nxt = '0;
      row_nxt = '0;
      min_nxt = wmds_pkg::init_min(k_new);
    end else if (adv && cell_valid) begin
      if (!row_end) begin
        col_nxt = col_r + OFS_W'(1);
        min_nxt = min_upd;
      end else if (!point_end) begin
        col_nxt = '0;
        row_nxt = row_r + OFS_W'(1);
        min_nxt = min_upd;
      end else begin
        col_nxt       = '0;
        row_nxt       = '0;
        min_nxt       = wmds_pkg::init_min(k);
        sum_nxt       = last_scan ? '0 : sum_sat;
        res_nxt.valid = 1'b1;
        res_nxt.pmin  = min_upd;
        res_nxt.sum   = sum_sat;
        res_nxt.last  = last_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      min_r <= wmds_pkg::init_min(clamp(wmds_pkg::RADIUS_RST));
      sum_r <= '0;
      res_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      min_r <= min_nxt;
      sum_r <= sum_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/core/wmds_score.sv
// Score stages: sum x coef, shift and negate if last point else zero, output reg.
// Depends on wmds_pkg.
module wmds_score (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  wmds_pkg::point_res_t          res,
  input  logic [wmds_pkg::COEF_W-1:0]   coef,
  output logic                          out_valid,
  output logic [wmds_pkg::DIST_W-1:0]   out_point_min_distance,
  output logic [wmds_pkg::SUM_W-1:0]    out_distance_sum,
  output logic signed [wmds_pkg::SCORE_W-1:0] out_scan_score,
  output logic                          out_scan_done
);

  wmds_pkg::point_res_t          mul_r;
  logic [wmds_pkg::PROD_W-1:0]   prod_r;
  logic                          o_valid_r;
  logic [wmds_pkg::DIST_W-1:0]   o_pmin_r;
  logic [wmds_pkg::SUM_W-1:0]    o_sum_r;
  logic [wmds_pkg::SCORE_W-1:0]  o_score_r, score_nxt;
  logic                          o_done_r;

  always_comb begin
    score_nxt = '0;
    if (mul_r.last) begin
      score_nxt = wmds_pkg::SCORE_W'(0) -
                  wmds_pkg::SCORE_W'(prod_r[wmds_pkg::PROD_W-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r     <= '0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      mul_r     <= res;
      o_valid_r <= mul_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= wmds_pkg::PROD_W'(res.sum) * wmds_pkg::PROD_W'(coef);
      o_pmin_r   <= mul_r.pmin;
      o_sum_r    <= mul_r.sum;
      o_score_r  <= score_nxt;
      o_done_r   <= mul_r.last;
    end
  end

  assign out_valid              = o_valid_r;
  assign out_point_min_distance = o_pmin_r;
  assign out_distance_sum       = o_sum_r;
  assign out_scan_score         = o_score_r;
  assign out_scan_done          = o_done_r;

endmodule

// File: rtl/core/window_min_distance_scan_score.sv
// Top level of the window minimum-distance scan scorer.
// Depends on wmds_pkg, wmds_cfg, wmds_track, wmds_score.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    hit_value, missed_value, last_of_scan
//  out_     output     out_valid/out_ready  point_min_distance, distance_sum,
//                                           scan_score, scan_done
//  cfg_     input      cfg_we               cfg_index, cfg_data
//
// One cell pair per cycle sustained while the output register is empty or taken.
// The pipeline is input register, min/sum update, multiplier, score/output register.
// All stages advance together whenever the output register is empty or taken.
// Reset (rst_n, synchronous) clears valids, offsets and sum and loads register defaults.
module window_min_distance_scan_score #(
  parameter int unsigned MAX_RADIUS = wmds_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wmds_pkg::VAL_W-1:0]    in_hit_value,
  input  logic [wmds_pkg::VAL_W-1:0]    in_missed_value,
  input  logic                          in_last_of_scan,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wmds_pkg::DIST_W-1:0]   out_point_min_distance,
  output logic [wmds_pkg::SUM_W-1:0]    out_distance_sum,
  output logic signed [wmds_pkg::SCORE_W-1:0] out_scan_score,
  output logic                          out_scan_done,
  input  logic                          cfg_we,
  input  logic [wmds_pkg::IDX_W-1:0]    cfg_index,
  input  logic [wmds_pkg::CFG_W-1:0]    cfg_data
);

  wmds_pkg::cfg_t              cfg;
  wmds_pkg::point_res_t        res;
  logic                        adv;
  logic                        s1_valid_r;
  logic [wmds_pkg::VAL_W-1:0]  s1_hit_r;
  logic [wmds_pkg::VAL_W-1:0]  s1_missed_r;
  logic                        s1_last_r;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hit_r    <= in_hit_value;
      s1_missed_r <= in_missed_value;
      s1_last_r   <= in_last_of_scan;
    end
  end

  wmds_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wmds_track #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cell_valid (s1_valid_r),
    .hit        (s1_hit_r),
    .missed     (s1_missed_r),
    .last_scan  (s1_last_r),
    .cfg        (cfg),
    .res        (res)
  );

  wmds_score u_score (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .adv                    (adv),
    .res                    (res),
    .coef                   (cfg.coef),
    .out_valid              (out_valid),
    .out_point_min_distance (out_point_min_distance),
    .out_distance_sum       (out_distance_sum),
    .out_scan_score         (out_scan_score),
    .out_scan_done          (out_scan_done)
  );

endmodule
